// ===== src/assert_macros.svh =====
// Assertion macros for the top level, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Checks that a trigger is followed by a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("assertion failed");

// Checks that a trigger is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/dat_pkg.sv =====
// Types and constants shared by the deferred assignment timer table.
package dat_pkg;

   // Item kinds.
   localparam logic KIND_TICK     = 1'b0;
   localparam logic KIND_REGISTER = 1'b1;

   // Prescaler period after reset.
   localparam logic [15:0] PERIOD_RESET = 16'd244;

   // Request beat.
   typedef struct packed {
      logic              kind;
      logic [14:0]       var_index;
      logic signed [23:0] value_fixed;
      logic [14:0]       delay_periods;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [14:0]        out_index;
      logic signed [15:0] out_value;
      logic               last;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_PLACE,
      ST_FLUSH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic slot_clear;
      logic slot_next;
      logic read;
      logic note_free;
      logic write_match;
      logic write_dec;
      logic write_place;
      logic load_held;
      logic push_mid;
      logic push_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_register;
      logic tick_sweep;
      logic item_is_register;
      logic slot_last;
      logic pending;
      logic match;
      logic expire;
      logic free_found;
      logic held_valid;
      logic out_can_load;
   } status_type;

endpackage

// ===== src/dat_controller.sv =====
// Controller state machine that walks the slot table for one item at a time.
module dat_controller import dat_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      req_accept;
   logic      hold_off;

   assign req_accept = req_valid && !req_stall;

   // An expiry must wait while an older held result cannot move to the output.
   assign hold_off = status.expire && status.held_valid && !status.out_can_load;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (status.req_is_register || status.tick_sweep)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.item_is_register) begin
               if (status.match) begin
                  state_in = ST_IDLE;
               end else if (status.slot_last) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_READ;
               end
            end else if (!hold_off) begin
               state_in = status.slot_last ? ST_FLUSH : ST_READ;
            end
         end
         ST_PLACE: begin
            state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (!status.held_valid || status.out_can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.capture    = req_valid;
            cmd.slot_clear = req_valid;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_EVAL: begin
            if (status.item_is_register) begin
               if (status.match) begin
                  cmd.write_match = 1'b1;
               end else begin
                  cmd.note_free = 1'b1;
                  cmd.slot_next = !status.slot_last;
               end
            end else if (!hold_off) begin
               cmd.write_dec = status.pending;
               cmd.load_held = status.expire;
               cmd.push_mid  = status.expire && status.held_valid;
               cmd.slot_next = !status.slot_last;
            end
         end
         ST_PLACE: begin
            cmd.write_place = status.free_found;
         end
         ST_FLUSH: begin
            cmd.push_last = status.held_valid && status.out_can_load;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/dat_datapath.sv =====
// Slot memories, prescaler, value conversion and output register.
module dat_datapath import dat_pkg::*; #(
   parameter int SLOT_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_valid,
   input  logic [15:0] csr_data,
   input  logic        rsp_stall,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Captured item.
   req_type            item_ff;
   logic signed [15:0] amount_ff;

   // Period register and prescaler.
   logic [15:0] period_ff;
   logic [15:0] prescale_ff;
   logic [15:0] prescale_inc;
   logic        tick_sweep;

   // Slot walk.
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] free_slot_ff;
   logic              free_found_ff;

   // Slot storage; countdowns of never-written slots read as zero.
   logic [14:0]            target_mem [SLOT_COUNT];
   logic signed [15:0]     amount_mem [SLOT_COUNT];
   logic [14:0]            cd_mem     [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  written_ff;
   logic [14:0]            target_rd_ff;
   logic signed [15:0]     amount_rd_ff;
   logic [14:0]            cd_rd_ff;
   logic                   written_rd_ff;
   logic [14:0]            rd_cd;

   // Write port.
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [14:0]       wr_cd;

   // Held expiry and output register.
   logic               held_valid_ff;
   logic [14:0]        held_index_ff;
   logic signed [15:0] held_value_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               out_can_load;

   // Value conversion: ceil(value * 10 / 256), saturated to 16 bits.
   logic signed [27:0] scaled;
   logic signed [28:0] rounded;
   logic signed [20:0] tenths;
   logic signed [15:0] amount_in;

   always_comb begin
      scaled  = $signed({{4{req_data.value_fixed[23]}}, req_data.value_fixed}) * 28'sd10;
      rounded = $signed({scaled[27], scaled}) + 29'sd255;
      tenths  = 21'(rounded >>> 8);
      if (tenths > 21'sd32767) begin
         amount_in = 16'sd32767;
      end else if (tenths < -21'sd32768) begin
         amount_in = -16'sd32768;
      end else begin
         amount_in = $signed(tenths[15:0]);
      end
   end

   // Prescaler step for a tick beat; it saturates rather than wraps.
   assign prescale_inc = (prescale_ff == 16'hFFFF) ? prescale_ff : prescale_ff + 16'd1;
   assign tick_sweep   = prescale_inc >= period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= PERIOD_RESET;
         prescale_ff <= '0;
      end else begin
         if (csr_valid) begin
            period_ff <= csr_data;
         end
         if (cmd.capture && req_data.kind == KIND_TICK) begin
            prescale_ff <= tick_sweep ? 16'd0 : prescale_inc;
         end
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff   <= req_data;
         amount_ff <= amount_in;
      end
   end

   // Slot pointer and first free slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         free_slot_ff  <= '0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmd.slot_clear) begin
            slot_ff       <= '0;
            free_found_ff <= 1'b0;
         end else if (cmd.slot_next) begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end
         if (cmd.note_free && rd_cd == 15'd0 && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= slot_ff;
         end
      end
   end

   // Write port selection.
   assign wr_en   = cmd.write_match || cmd.write_dec || cmd.write_place;
   assign wr_addr = cmd.write_place ? free_slot_ff : slot_ff;
   assign wr_cd   = cmd.write_dec ? rd_cd - 15'd1 : item_ff.delay_periods;

   // Slot memories with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cd_mem[wr_addr] <= wr_cd;
      end
      if (cmd.write_match || cmd.write_place) begin
         amount_mem[wr_addr] <= amount_ff;
      end
      if (cmd.write_place) begin
         target_mem[wr_addr] <= item_ff.var_index;
      end
      if (cmd.read) begin
         cd_rd_ff     <= cd_mem[slot_ff];
         amount_rd_ff <= amount_mem[slot_ff];
         target_rd_ff <= target_mem[slot_ff];
      end
   end

   // Written flags stand in for the all-zero countdown reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         written_rd_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (cmd.read) begin
            written_rd_ff <= written_ff[slot_ff];
         end
      end
   end

   assign rd_cd = written_rd_ff ? cd_rd_ff : 15'd0;

   // Held expiry waits until the next one shows whether it is the last.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (cmd.load_held) begin
         held_valid_ff <= 1'b1;
      end else if (cmd.push_last) begin
         held_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_held) begin
         held_index_ff <= target_rd_ff;
         held_value_ff <= amount_rd_ff;
      end
   end

   // Output register.
   assign out_can_load = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push_mid || cmd.push_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_mid || cmd.push_last) begin
         rsp_data_ff.out_index <= held_index_ff;
         rsp_data_ff.out_value <= held_value_ff;
         rsp_data_ff.last      <= cmd.push_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status toward the controller.
   always_comb begin
      status                  = '0;
      status.req_is_register  = req_data.kind == KIND_REGISTER;
      status.tick_sweep       = tick_sweep;
      status.item_is_register = item_ff.kind == KIND_REGISTER;
      status.slot_last        = slot_ff == SLOT_W'(SLOT_COUNT - 1);
      status.pending          = rd_cd != 15'd0;
      status.match            = (rd_cd != 15'd0) && (target_rd_ff == item_ff.var_index);
      status.expire           = rd_cd == 15'd1;
      status.free_found       = free_found_ff;
      status.held_valid       = held_valid_ff;
      status.out_can_load     = out_can_load;
   end

endmodule

// ===== src/deferred_assignment_timer_table.sv =====
// Top level of the deferred assignment timer table.
//
//   channel  direction  handshake              beat
//   req      in         req_valid / req_stall  req_type: kind, index, value, delay
//   rsp      out        rsp_valid / rsp_stall  rsp_type: index, value, last
//   csr      in         csr_valid / csr_ready  ticks_per_period, 16 bits
//
// A tick that does not end a period is handled in the idle state. A register beat walks the
// slots and ends early at the first matching pending slot; else it writes the first free slot.
// A period-ending tick walks every slot and then flushes, waiting out any response stall.
// For each slot, one state reads the slot memories and the next evaluates and writes back.
// Reset is synchronous; it frees every slot at once and clears the prescaler.
// A stalled response holds the sweep at the next expiry until the output register frees.
`include "assert_macros.svh"

module deferred_assignment_timer_table import dat_pkg::*; #(
   parameter int SLOT_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // The period register is always writable.
   assign csr_ready = 1'b1;

   dat_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dat_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A result moves to the output only from a held expiry into a free register.
   `ASSERT_IMPLY(a_push_ok, clock, reset, cmd.push_mid || cmd.push_last,
                 status.held_valid && status.out_can_load)
   // At most one slot write per cycle.
   `ASSERT_ALWAYS(a_one_write, clock, reset,
                  $onehot0({cmd.write_match, cmd.write_dec, cmd.write_place}))
   // Every memory read is followed by an evaluate cycle, never a second read.
   `ASSERT_NEXT(a_read_eval, clock, reset, cmd.read, !cmd.read && req_stall)
   // Beats are taken only while the controller is idle.
   `ASSERT_IMPLY(a_capture_idle, clock, reset, cmd.capture, !req_stall)

endmodule

// ===== verif/deferred_assignment_timer_table_test.sv =====
// Self-checking testbench for the deferred assignment timer table.
module deferred_assignment_timer_table_test;
   import dat_pkg::*;

   localparam int SLOTS = 16;
   // Busy time of a register beat without a match, or of a period-ending tick without response stalls.
   localparam int SWEEP_CYCLES = 2 + 2 * SLOTS;
   localparam int SETTLE_CYCLES = 2 * SWEEP_CYCLES + 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   deferred_assignment_timer_table #(.SLOT_COUNT(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Beats waiting to be sent and expiries the table is due to report.
   req_type pending_beats[$];
   rsp_type due_expiries[$];

   // Shadow copy of the timer table.
   logic [14:0]        shadow_target[SLOTS];
   logic signed [15:0] shadow_amount[SLOTS];
   logic [14:0]        shadow_countdown[SLOTS];
   logic [15:0]        shadow_prescale;
   logic [15:0]        period_now;

   int   error_count;
   bit   idle_on;
   logic req_fire;
   int   req_gap;
   int   stall_left;
   int   hold_left;
   int   hold_asked;
   int   hold_seen;
   logic [14:0] index_pool[8];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   // Value in tenths: ceiling of value_fixed * 10 / 256, saturated to 16 bits.
   function automatic logic signed [15:0] tenths_of(logic signed [23:0] raw);
      int scaled;
      int rounded;
      scaled = int'(raw) * 10;
      if (scaled >= 0) begin
         rounded = (scaled + 255) / 256;
      end else begin
         rounded = -((-scaled) / 256);
      end
      if (rounded > 32767) rounded = 32767;
      if (rounded < -32768) rounded = -32768;
      return rounded[15:0];
   endfunction

   // Applies one accepted beat to the shadow table and queues the expiries it causes.
   function automatic void advance_timer_table(req_type beat);
      bit      done;
      bit      have_held;
      rsp_type held;
      done = 1'b0;
      have_held = 1'b0;
      held = '0;
      if (beat.kind == KIND_REGISTER) begin
         // A pending slot with the same index is rewritten first.
         for (int i = 0; i < SLOTS; i++) begin
            if (!done && shadow_countdown[i] != 0 && shadow_target[i] == beat.var_index) begin
               shadow_amount[i] = tenths_of(beat.value_fixed);
               shadow_countdown[i] = beat.delay_periods;
               done = 1'b1;
            end
         end
         // Otherwise the first free slot takes it; a full table drops the beat.
         for (int i = 0; i < SLOTS; i++) begin
            if (!done && shadow_countdown[i] == 0) begin
               shadow_target[i] = beat.var_index;
               shadow_amount[i] = tenths_of(beat.value_fixed);
               shadow_countdown[i] = beat.delay_periods;
               done = 1'b1;
            end
         end
      end else begin
         if (shadow_prescale != 16'hFFFF) shadow_prescale = shadow_prescale + 16'd1;
         if (shadow_prescale >= period_now) begin
            shadow_prescale = '0;
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_countdown[i] != 0) begin
                  shadow_countdown[i] = shadow_countdown[i] - 15'd1;
                  if (shadow_countdown[i] == 0) begin
                     if (have_held) due_expiries.push_back(held);
                     held.out_index = shadow_target[i];
                     held.out_value = shadow_amount[i];
                     held.last = 1'b0;
                     have_held = 1'b1;
                  end
               end
            end
            // The final expiry of the sweep carries last.
            if (have_held) begin
               held.last = 1'b1;
               due_expiries.push_back(held);
            end
         end
      end
   endfunction

   // Monitor: predicts on accepted request beats and checks accepted response beats.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            shadow_target[i] = '0;
            shadow_amount[i] = '0;
            shadow_countdown[i] = '0;
         end
         shadow_prescale = '0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) advance_timer_table(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (due_expiries.size() == 0) begin
               $display("%0t: unexpected response beat, actual %h", $realtime, rsp_data);
               error_count++;
            end else begin
               want = due_expiries.pop_front();
               if (rsp_data.out_index !== want.out_index) begin
                  $display("%0t: out_index expected %h actual %h", $realtime,
                           want.out_index, rsp_data.out_index);
                  error_count++;
               end
               if (rsp_data.out_value !== want.out_value) begin
                  $display("%0t: out_value expected %h actual %h", $realtime,
                           want.out_value, rsp_data.out_value);
                  error_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $realtime,
                           want.last, rsp_data.last);
                  error_count++;
               end
            end
         end
      end
   end

   // Driver: offers queued beats with random gaps, holding a stalled beat steady.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && !req_fire) begin
         // Stalled beat stays on the bus.
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         req_gap <= $urandom_range(0, 16);
         req_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
         req_data <= pending_beats.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random stall bursts, plus a long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= 299;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic queue_register(input logic [14:0] index, input logic [23:0] value,
                                 input logic [14:0] delay);
      req_type beat;
      beat.kind = KIND_REGISTER;
      beat.var_index = index;
      beat.value_fixed = value;
      beat.delay_periods = delay;
      pending_beats.push_back(beat);
   endtask

   // Tick beats carry random noise in the unused fields.
   task automatic queue_ticks(input int count);
      req_type beat;
      for (int i = 0; i < count; i++) begin
         beat.kind = KIND_TICK;
         beat.var_index = 15'($urandom);
         beat.value_fixed = 24'($urandom);
         beat.delay_periods = 15'($urandom);
         pending_beats.push_back(beat);
      end
   endtask

   // Random beats: mostly registrations on a small set of indexes so matches happen.
   task automatic queue_random(input int count);
      logic [14:0] index;
      logic [23:0] value;
      logic [14:0] delay;
      int          pick;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 45) begin
            queue_ticks(1);
         end else begin
            if ($urandom_range(0, 99) < 85) index = index_pool[3'($urandom_range(0, 7))];
            else index = 15'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 5) value = 24'($urandom_range(0, 1800000) - 900000);
            else if (pick < 9) value = 24'($urandom);
            else value = 24'($urandom_range(0, 600) - 300);
            pick = $urandom_range(0, 99);
            if (pick < 10) delay = '0;
            else if (pick < 85) delay = 15'($urandom_range(1, 4));
            else delay = 15'($urandom);
            queue_register(index, value, delay);
         end
      end
   endtask

   // Waits until every beat is sent, every expiry has come, and the table is quiet.
   task automatic wait_quiet();
      @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || due_expiries.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] ticks);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= ticks;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      period_now = ticks;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      error_count = 0;
      idle_on = 1'b1;
      hold_asked = 0;
      period_now = PERIOD_RESET;
      index_pool[0] = 15'd0;
      index_pool[1] = 15'h7FFF;
      for (int i = 2; i < 8; i++) index_pool[i] = 15'($urandom);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset period: extremes of value and delay, no sweep yet.
      queue_register(15'd0, 24'h7FFFFF, 15'd1);
      queue_register(15'h7FFF, 24'h800000, 15'd2);
      queue_register(15'd100, 24'd256, 15'h7FFF);
      queue_ticks(5);
      wait_quiet();

      // Period lowered below the prescaler count sweeps on the next tick.
      write_period(16'd3);
      queue_ticks(1);
      // Zero delay cancels a match; without a match the slot stays free.
      queue_register(15'd100, 24'hFFFFFF, 15'd0);
      queue_register(15'd7, 24'd1, 15'd0);
      // Rounding toward the ceiling on both signs.
      queue_register(15'd7, -24'sd255, 15'd1);
      queue_register(15'd8, 24'd25, 15'd1);
      queue_register(15'd9, 24'd0, 15'd2);
      queue_ticks(6);
      wait_quiet();

      // Full table: the extra index is dropped, a known index still matches.
      write_period(16'd1);
      for (int i = 0; i < SLOTS; i++) queue_register(15'(200 + i), 24'($urandom), 15'd1);
      queue_register(15'd999, 24'd512, 15'd1);
      queue_register(15'd203, 24'd77, 15'd2);
      wait_quiet();

      // Long receiver hold-off while beats keep coming, so the input backs up.
      hold_asked = hold_asked + 1;
      queue_ticks(2);
      queue_random(12);
      wait_quiet();

      write_period(16'd2);
      queue_random(12);
      wait_quiet();

      // Longest period: no sweep; then the shortest, which sweeps at once.
      write_period(16'hFFFF);
      queue_random(6);
      wait_quiet();
      write_period(16'd1);
      queue_random(12);
      wait_quiet();

      write_period(16'd4);
      queue_random(8);
      wait_quiet();

      // Closing stretch with neither side idling.
      idle_on = 1'b0;
      write_period(16'd1);
      queue_random(10);
      wait_quiet();

      if (error_count == 0 && due_expiries.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/dat_pkg.sv
src/dat_controller.sv
src/dat_datapath.sv
src/deferred_assignment_timer_table.sv
verif/deferred_assignment_timer_table_test.sv
